### rtl/core/hrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrd_pkg;

  // Width of the body length accumulator and the body byte counter.
  localparam int COUNT_WIDTH = 24;

  // Width of the accumulator before the limit compare (value * 10 + digit).
  localparam int ACC_WIDTH = COUNT_WIDTH + 4;

  // Parse phases, also reported on the status output.
  localparam logic [3:0] PH_STATUS     = 4'd0;
  localparam logic [3:0] PH_SEEK_LEN   = 4'd1;
  localparam logic [3:0] PH_SEEK_END   = 4'd2;
  localparam logic [3:0] PH_BODY       = 4'd3;
  localparam logic [3:0] PH_DONE       = 4'd4;
  localparam logic [3:0] PH_BAD_STATUS = 4'd5;
  localparam logic [3:0] PH_NO_LEN     = 4'd6;
  localparam logic [3:0] PH_EARLY_END  = 4'd7;
  localparam logic [3:0] PH_TOO_LARGE  = 4'd8;

  // Marker lengths and the offset of the header-end match in the match index.
  localparam logic [4:0] STATUS_LEN = 5'd15;
  localparam logic [4:0] LENTAG_LEN = 5'd16;
  localparam logic [4:0] END_BASE   = 5'd16;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Characters of the required status line "HTTP/1.1 200 OK".
  function automatic logic [7:0] status_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "H";
      5'd1:    c = "T";
      5'd2:    c = "T";
      5'd3:    c = "P";
      5'd4:    c = "/";
      5'd5:    c = "1";
      5'd6:    c = ".";
      5'd7:    c = "1";
      5'd8:    c = " ";
      5'd9:    c = "2";
      5'd10:   c = "0";
      5'd11:   c = "0";
      5'd12:   c = " ";
      5'd13:   c = "O";
      5'd14:   c = "K";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of the length field tag "Content-Length: ".
  function automatic logic [7:0] tag_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "C";
      5'd1:    c = "o";
      5'd2:    c = "n";
      5'd3:    c = "t";
      5'd4:    c = "e";
      5'd5:    c = "n";
      5'd6:    c = "t";
      5'd7:    c = "-";
      5'd8:    c = "L";
      5'd9:    c = "e";
      5'd10:   c = "n";
      5'd11:   c = "g";
      5'd12:   c = "t";
      5'd13:   c = "h";
      5'd14:   c = ":";
      5'd15:   c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of the blank line CR LF CR LF that ends the header.
  function automatic logic [7:0] end_char(input logic [1:0] k);
    return k[0] ? CH_LF : CH_CR;
  endfunction

endpackage

`default_nettype wire

### rtl/core/http_response_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_ready  | in_data_byte, in_stream_end, in_new_response
// result   | out       | out_valid / out_ready| out_body_byte, out_body_valid,
//          |           |                      | out_parse_status, out_bytes_received
// config   | in        | cfg_wr_en            | cfg_wr_data (max_body_bytes)
//
// Every input beat yields exactly one result beat, registered in the cycle after acceptance.
// Throughput is one beat per cycle while the output is not stalled; the matchers, the multiply-by-ten and the
// limit compare sit between the parser state and the result register.
// A new beat is taken whenever the result register is empty or is being
// drained in the same cycle, so a stalled output holds back only one beat.
// Synchronous active-low reset clears the parser state and sets the body
// limit to its maximum.

module http_response_deframer
  import hrd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_stream_end,
  input  wire logic        in_new_response,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_body_byte,
  output logic             out_body_valid,
  output logic [3:0]       out_parse_status,
  output logic [23:0]      out_bytes_received
);

  // Configuration and parser state.
  logic [23:0]            max_body_r;
  logic [3:0]             phase_r,   phase_nxt;
  logic [4:0]             match_r,   match_nxt;
  logic                   digits_r,  digits_nxt;
  logic [COUNT_WIDTH-1:0] exp_len_r, exp_len_nxt;
  logic [COUNT_WIDTH-1:0] rx_cnt_r,  rx_cnt_nxt;

  // Result register.
  logic                   out_valid_r;
  logic [7:0]             body_byte_r,  body_byte_nxt;
  logic                   body_valid_r, body_valid_nxt;

  // Working values after an optional clear by new_response.
  logic [3:0]             ph_cur;
  logic [4:0]             match_cur;
  logic                   digits_cur;
  logic [COUNT_WIDTH-1:0] exp_len_cur;
  logic [COUNT_WIDTH-1:0] rx_cnt_cur;

  logic [7:0]             b;
  logic                   accept;
  logic                   is_digit;
  logic                   is_cr;
  logic                   is_crlf;
  logic [ACC_WIDTH-1:0]   acc_val;
  logic [ACC_WIDTH-1:0]   limit_ext;
  logic [COUNT_WIDTH-1:0] rx_inc;
  logic [1:0]             end_k;
  logic [4:0]             tag_idx;

  assign b        = in_data_byte;
  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign is_cr    = (b == CH_CR);
  assign is_crlf  = is_cr || (b == CH_LF);
  assign is_digit = b inside {[CH_ZERO:CH_NINE]};

  // Clear the parser before this beat when a new response starts.
  assign ph_cur      = in_new_response ? PH_STATUS : phase_r;
  assign match_cur   = in_new_response ? 5'd0 : match_r;
  assign digits_cur  = in_new_response ? 1'b0 : digits_r;
  assign exp_len_cur = in_new_response ? '0 : exp_len_r;
  assign rx_cnt_cur  = in_new_response ? '0 : rx_cnt_r;

  // Decimal accumulation: value * 8 + value * 2 + digit, compared against the limit.
  assign acc_val   = ACC_WIDTH'({exp_len_cur, 3'b000})
                     + ACC_WIDTH'({exp_len_cur, 1'b0})
                     + ACC_WIDTH'(b[3:0]);
  assign limit_ext = ACC_WIDTH'(max_body_r);

  assign rx_inc  = rx_cnt_cur + COUNT_WIDTH'(1);
  assign end_k   = match_cur[1:0];
  assign tag_idx = (match_cur >= END_BASE) ? 5'd0 : match_cur;

  // Next parser state and result for the beat at the input.
  always_comb begin
    phase_nxt      = ph_cur;
    match_nxt      = match_cur;
    digits_nxt     = digits_cur;
    exp_len_nxt    = exp_len_cur;
    rx_cnt_nxt     = rx_cnt_cur;
    body_valid_nxt = 1'b0;
    body_byte_nxt  = 8'h00;

    if (in_stream_end) begin
      if (ph_cur <= PH_BODY) begin
        phase_nxt = PH_EARLY_END;
      end
    end else begin
      case (ph_cur)
        PH_STATUS: begin
          if (match_cur < STATUS_LEN && b == status_char(match_cur)) begin
            if (match_cur == STATUS_LEN - 5'd1) begin
              phase_nxt = PH_SEEK_LEN;
              match_nxt = 5'd0;
            end else begin
              match_nxt = match_cur + 5'd1;
            end
          end else begin
            phase_nxt = PH_BAD_STATUS;
          end
        end

        PH_SEEK_LEN: begin
          if (digits_cur) begin
            // Inside the length value: 0 before digits, 1 in digits, 2 after.
            if (is_crlf) begin
              digits_nxt = 1'b0;
              if (exp_len_cur == '0) begin
                phase_nxt = PH_NO_LEN;
                match_nxt = 5'd0;
              end else begin
                phase_nxt = PH_SEEK_END;
                match_nxt = is_cr ? 5'd1 : 5'd0;
              end
            end else if (is_digit && match_cur < 5'd2) begin
              match_nxt = 5'd1;
              if (acc_val > limit_ext) begin
                exp_len_nxt = COUNT_WIDTH'(max_body_r);
                phase_nxt   = PH_TOO_LARGE;
                digits_nxt  = 1'b0;
              end else begin
                exp_len_nxt = acc_val[COUNT_WIDTH-1:0];
              end
            end else if ((b == CH_SPACE || b == CH_TAB) && match_cur == 5'd0) begin
              match_nxt = match_cur;
            end else begin
              match_nxt = 5'd2;
            end
          end else if (match_cur >= END_BASE
                       && b == end_char(end_k)) begin
            // Blank line found before any length field.
            if (end_k == 2'd3) begin
              phase_nxt = PH_NO_LEN;
              match_nxt = 5'd0;
            end else begin
              match_nxt = match_cur + 5'd1;
            end
          end else if (b == tag_char(tag_idx)) begin
            if (tag_idx == LENTAG_LEN - 5'd1) begin
              digits_nxt  = 1'b1;
              match_nxt   = 5'd0;
              exp_len_nxt = '0;
            end else begin
              match_nxt = tag_idx + 5'd1;
            end
          end else if (b == tag_char(5'd0)) begin
            match_nxt = 5'd1;
          end else if (is_cr) begin
            match_nxt = END_BASE + 5'd1;
          end else begin
            match_nxt = 5'd0;
          end
        end

        PH_SEEK_END: begin
          if (b == end_char(end_k)) begin
            if (end_k == 2'd3) begin
              phase_nxt  = PH_BODY;
              match_nxt  = 5'd0;
              rx_cnt_nxt = '0;
            end else begin
              match_nxt = {3'b000, end_k} + 5'd1;
            end
          end else begin
            match_nxt = is_cr ? 5'd1 : 5'd0;
          end
        end

        PH_BODY: begin
          body_valid_nxt = 1'b1;
          body_byte_nxt  = b;
          rx_cnt_nxt     = rx_inc;
          if (rx_inc >= exp_len_cur) begin
            phase_nxt = PH_DONE;
          end
        end

        default: begin
          // Done, error and unused codes are terminal.
          phase_nxt = ph_cur;
        end
      endcase
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= 24'hffffff;
    end else if (cfg_wr_en) begin
      max_body_r <= cfg_wr_data;
    end
  end

  // Parser state advances on every accepted input beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_STATUS;
      match_r   <= 5'd0;
      digits_r  <= 1'b0;
      exp_len_r <= '0;
      rx_cnt_r  <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      match_r   <= match_nxt;
      digits_r  <= digits_nxt;
      exp_len_r <= exp_len_nxt;
      rx_cnt_r  <= rx_cnt_nxt;
    end
  end

  // Result register: filled on accept, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      body_byte_r  <= body_byte_nxt;
      body_valid_r <= body_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_body_byte      = body_byte_r;
  assign out_body_valid     = body_valid_r;
  assign out_parse_status   = phase_r;
  assign out_bytes_received = 24'(rx_cnt_r);

endmodule

`default_nettype wire
